FILE: design/lfpr_pkg.sv
// ============================================================================
// lfpr_pkg
// Shared types and constants for the length-framed packet receiver.
// ============================================================================
`default_nettype none

package lfpr_pkg;

    // Largest body length plus one; the high length byte is limited to below MAX_BODY >> 8
    localparam int unsigned MAX_BODY     = 1024;
    localparam int unsigned LEN_HI_LIMIT = MAX_BODY >> 8;

    localparam logic [7:0]  HEADER_BYTE = 8'hF9;
    localparam logic [15:0] SEED        = 16'h5555;
    localparam logic [15:0] LOW_MASK    = 16'h00FF;
    localparam logic [7:0]  LEN_ADJ     = 8'd2;

    localparam int unsigned REM_W = 16;
    localparam int unsigned CNT_W = 10;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_LEN_LO = 2'd2,
        PH_BODY   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        FS_NONE = 2'd0,
        FS_GOOD = 2'd1,
        FS_BAD  = 2'd2
    } t_frame_status;

    typedef struct packed {
        t_frame_status      frame_status;
        logic               body_valid;
        logic [7:0]         body_byte;
        logic [CNT_W-1:0]   body_index;
        logic [CNT_W-1:0]   body_count;
    } t_result;

endpackage

`default_nettype wire

FILE: design/lfpr_if.sv
// ============================================================================
// lfpr_rx_if / lfpr_res_if
// Valid/ready channels for received bytes and per-byte results.
// ============================================================================
`default_nettype none

interface lfpr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfpr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] frame_status;
    logic       body_valid;
    logic [7:0] body_byte;
    logic [9:0] body_index;
    logic [9:0] body_count;

    modport source (output valid, output frame_status, output body_valid,
                    output body_byte, output body_index, output body_count,
                    input ready);
    modport sink   (input valid, input frame_status, input body_valid,
                    input body_byte, input body_index, input body_count,
                    output ready);
endinterface

`default_nettype wire

FILE: design/length_framed_packet_receiver.sv
// ============================================================================
// length_framed_packet_receiver
// Byte-wise receiver for 0xF9-headed, length-framed packets with XOR check.
// ============================================================================
// Accepts one received byte per clock, unless the output stalls, and returns
// exactly one result item per byte. A byte is held in the input register,
// parsed, and its result is registered in the output stage. The rate is one
// item per cycle while the output is not stalled, set by the update of the
// frame state (phase, remaining count, checksum, two-entry history, body
// count) in the parser stage. Body bytes come out with a descending index
// equal to the remaining count; a frame's last byte reports checksum good or bad.
`default_nettype none

module length_framed_packet_receiver (
    input  wire          i_clk,
    input  wire          i_rst_n,
    lfpr_rx_if.sink      i_rx,
    lfpr_res_if.source   o_res
);
    import lfpr_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       take;
    logic       res_free;
    t_result    res;

    lfpr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    lfpr_frame_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_byte     (in_byte),
        .i_res_free (res_free),
        .o_take     (take),
        .o_res      (res)
    );

    lfpr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_res   (res),
        .o_free  (res_free),
        .o_res   (o_res)
    );
endmodule

`default_nettype wire

FILE: design/lfpr_in_stage.sv
// ============================================================================
// lfpr_in_stage
// Input register for received bytes; refills in the cycle it drains.
// ============================================================================
`default_nettype none

module lfpr_in_stage (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lfpr_rx_if.sink    i_rx,
    input  wire        i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import lfpr_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    // free when empty or when the held item moves on this cycle
    assign i_rx.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

`default_nettype wire

FILE: design/lfpr_frame_fsm.sv
// ============================================================================
// lfpr_frame_fsm
// Frame parser state and checksum: one byte per cycle while the result register is free, builds one result.
// ============================================================================
`default_nettype none

module lfpr_frame_fsm (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire  [7:0]          i_byte,
    input  wire                 i_res_free,
    output logic                o_take,
    output lfpr_pkg::t_result   o_res
);
    import lfpr_pkg::*;

    t_phase             r_phase,   n_phase;
    logic [REM_W-1:0]   r_rem,     n_rem;
    logic [7:0]         r_chk,     n_chk;
    logic [7:0]         r_hist0,   n_hist0;
    logic [7:0]         r_hist1,   n_hist1;
    logic [CNT_W-1:0]   r_cnt,     n_cnt;

    assign o_take = i_valid && i_res_free;

    // state registers, updated once per byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_rem   <= '0;
            r_chk   <= '0;
            r_hist0 <= '0;
            r_hist1 <= '0;
            r_cnt   <= '0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_chk   <= n_chk;
            r_hist0 <= n_hist0;
            r_hist1 <= n_hist1;
            r_cnt   <= n_cnt;
        end
    end

    // next state and result for the byte in the input register
    always_comb begin
        logic [REM_W-1:0] rem_dec;
        logic [REM_W-1:0] rem_lo;
        logic [7:0]       adj;
        logic [7:0]       hdr_cand;
        logic             hdr_test;
        logic             shift;

        rem_dec  = r_rem - REM_W'(1);
        adj      = i_byte - LEN_ADJ;
        rem_lo   = rem_dec + {8'h00, adj};
        hdr_cand = i_byte;
        hdr_test = 1'b0;
        shift    = 1'b1;

        n_phase = r_phase;
        n_rem   = rem_dec;
        n_chk   = r_chk ^ i_byte;
        n_cnt   = r_cnt;

        o_res.frame_status = FS_NONE;
        o_res.body_valid   = 1'b0;
        o_res.body_byte    = '0;
        o_res.body_index   = '0;

        case (r_phase)
            PH_HEADER: begin
                hdr_test = 1'b1;
            end
            PH_LEN_HI: begin
                if (i_byte >= 8'(LEN_HI_LIMIT)) begin
                    n_phase  = PH_HEADER;
                    n_rem    = '0;
                    hdr_test = 1'b1;
                end else begin
                    n_rem   = {i_byte, 8'h00};
                    n_phase = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                if (rem_lo >= REM_W'(MAX_BODY)) begin
                    // oversize length: abort, adjusted byte may start a frame
                    n_phase  = PH_HEADER;
                    n_rem    = '0;
                    hdr_cand = adj;
                    hdr_test = 1'b1;
                end else begin
                    n_rem   = rem_lo;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (rem_dec != '0) begin
                    if (rem_dec < REM_W'(MAX_BODY)) begin
                        o_res.body_valid = 1'b1;
                        o_res.body_byte  = i_byte;
                        o_res.body_index = rem_dec[CNT_W-1:0];
                        n_cnt            = r_cnt + CNT_W'(1);
                    end else begin
                        // count wrapped past zero: abort
                        n_phase  = PH_HEADER;
                        n_rem    = '0;
                        hdr_test = 1'b1;
                    end
                end else begin
                    // last byte: compare against the older history entry
                    n_phase            = PH_HEADER;
                    shift              = 1'b0;
                    o_res.frame_status = (i_byte == r_hist1) ? FS_GOOD : FS_BAD;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        // header match reseeds the checksum and restarts the body count
        if (hdr_test && (hdr_cand == HEADER_BYTE)) begin
            n_phase = PH_LEN_HI;
            n_chk   = 8'((SEED ^ {8'h00, hdr_cand}) & LOW_MASK);
            n_cnt   = '0;
        end

        if (shift) begin
            n_hist1 = r_hist0;
            n_hist0 = n_chk;
        end else begin
            n_hist1 = r_hist1;
            n_hist0 = r_hist0;
        end

        o_res.body_count = n_cnt;
    end
endmodule

`default_nettype wire

FILE: design/lfpr_out_stage.sv
// ============================================================================
// lfpr_out_stage
// Result register; takes a new result while the held one is being taken.
// ============================================================================
`default_nettype none

module lfpr_out_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  lfpr_pkg::t_result   i_res,
    output logic                o_free,
    lfpr_res_if.source          o_res
);
    import lfpr_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.frame_status = r_res.frame_status;
    assign o_res.body_valid   = r_res.body_valid;
    assign o_res.body_byte    = r_res.body_byte;
    assign o_res.body_index   = r_res.body_index;
    assign o_res.body_count   = r_res.body_count;
endmodule

`default_nettype wire

FILE: design/lfpr_checker.sv
// ============================================================================
// lfpr_checker
// Port-level checks on the receiver's result channel.
// ============================================================================
`default_nettype none

module lfpr_checker (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    input  wire       i_ready,
    input  wire [1:0] i_frame_status,
    input  wire       i_body_valid,
    input  wire [7:0] i_body_byte,
    input  wire [9:0] i_body_index,
    input  wire [9:0] i_body_count
);
    import lfpr_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_frame_status)
            && $stable(i_body_valid) && $stable(i_body_byte)
            && $stable(i_body_index) && $stable(i_body_count))
        else $error("result changed while stalled");

    // a body byte never ends a frame and never carries index zero
    a_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_body_valid |-> i_frame_status == FS_NONE && i_body_index != 10'd0)
        else $error("body byte with end status or zero index");

    // non-body results carry zero byte and index
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_body_valid |-> i_body_byte == 8'd0 && i_body_index == 10'd0)
        else $error("non-body result with body payload");

    // only the defined status codes appear
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_frame_status == FS_NONE || i_frame_status == FS_GOOD
            || i_frame_status == FS_BAD)
        else $error("illegal frame status");
endmodule

bind length_framed_packet_receiver lfpr_checker u_lfpr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_frame_status (o_res.frame_status),
    .i_body_valid   (o_res.body_valid),
    .i_body_byte    (o_res.body_byte),
    .i_body_index   (o_res.body_index),
    .i_body_count   (o_res.body_count)
);

`default_nettype wire
